FILE: hdl/rtc_match_alarm_registers_macros.svh
// Assertion macros for the RTC match-alarm register block.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef RTC_MATCH_ALARM_REGISTERS_MACROS_SVH
`define RTC_MATCH_ALARM_REGISTERS_MACROS_SVH

// Same-cycle implication.
`define RTCMA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RTCMA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/rtcma_pkg.sv
// ----------------------------------------------------------------------------
// rtcma_pkg
// Types, register offsets and constants shared by the RTC match-alarm block.
// ----------------------------------------------------------------------------
`default_nettype none

package rtcma_pkg;

  localparam logic [31:0] FIXED_EPOCH = 32'd1735689600;

  // Request codes.
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // Register map.
  localparam logic [11:0] ADDR_DR   = 12'h000;
  localparam logic [11:0] ADDR_MR   = 12'h004;
  localparam logic [11:0] ADDR_LR   = 12'h008;
  localparam logic [11:0] ADDR_CR   = 12'h00c;
  localparam logic [11:0] ADDR_IMSC = 12'h010;
  localparam logic [11:0] ADDR_RIS  = 12'h014;
  localparam logic [11:0] ADDR_MIS  = 12'h018;
  localparam logic [11:0] ADDR_ICR  = 12'h01c;
  localparam logic [11:0] ID_BASE   = 12'hfe0;
  localparam logic [11:0] ID_LAST   = 12'hffc;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [11:0] offset;
    logic [31:0] write_data;
    logic [31:0] host_seconds;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_level;
  } res_t;

  // Alarm state seen by the top level's checks.
  typedef struct packed {
    logic armed;
    logic raw;
    logic tick_fire;
  } rtcma_status_t;

  // Peripheral and cell ID bytes, one per word of the ID window.
  function automatic logic [7:0] id_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h31;
      3'd1:    b = 8'h10;
      3'd2:    b = 8'h14;
      3'd3:    b = 8'h00;
      3'd4:    b = 8'h0d;
      3'd5:    b = 8'hf0;
      3'd6:    b = 8'h05;
      default: b = 8'hb1;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/rtcma_if.sv
// ----------------------------------------------------------------------------
// rtcma_if
// Request and result channel interfaces with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtcma_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [11:0] offset;
  logic [31:0] write_data;
  logic [31:0] host_seconds;

  modport source (output valid, req_type, offset, write_data, host_seconds, input ready);
  modport sink   (input valid, req_type, offset, write_data, host_seconds, output ready);
endinterface

interface rtcma_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq_level;

  modport source (output valid, read_data, irq_level, input ready);
  modport sink   (input valid, read_data, irq_level, output ready);
endinterface

`default_nettype wire

FILE: hdl/rtcma_in_stage.sv
// ----------------------------------------------------------------------------
// rtcma_in_stage
// Input register: captures one request and holds it until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rtcma_in_stage
  import rtcma_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  input  logic advance,
  output logic req_valid,
  output req_t req
);

  logic valid_r;
  logic valid_nxt;
  req_t req_r;

  // A new request may enter in the same cycle the held one moves on.
  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r <= in_req;
    end
  end

  assign req_valid = valid_r;
  assign req       = req_r;

endmodule

`default_nettype wire

FILE: hdl/rtcma_core.sv
// ----------------------------------------------------------------------------
// rtcma_core
// Register file, visible count and one-shot match alarm.
// ----------------------------------------------------------------------------
`default_nettype none

module rtcma_core
  import rtcma_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  input  logic          advance,
  input  req_t          req,
  output res_t          res,
  output rtcma_status_t status
);

  logic        live_r;
  logic [31:0] match_r,   match_nxt;
  logic [31:0] load_r,    load_nxt;
  logic [31:0] ctrl_r,    ctrl_nxt;
  logic [31:0] mask_r,    mask_nxt;
  logic [31:0] cnt_ofs_r, cnt_ofs_nxt;
  logic        raw_r,     raw_nxt;
  logic        armed_r,   armed_nxt;

  logic [31:0] host_cnt;
  logic [31:0] vis_cnt;
  logic [31:0] rd;
  logic        in_id;
  logic        fire;

  assign host_cnt = live_r ? req.host_seconds : FIXED_EPOCH;
  assign vis_cnt  = host_cnt + cnt_ofs_r;
  assign in_id    = (req.offset >= ID_BASE) && (req.offset <= ID_LAST);

  always_comb begin
    match_nxt   = match_r;
    load_nxt    = load_r;
    ctrl_nxt    = ctrl_r;
    mask_nxt    = mask_r;
    cnt_ofs_nxt = cnt_ofs_r;
    raw_nxt     = raw_r;
    armed_nxt   = armed_r;
    rd          = '0;
    fire        = 1'b0;
    case (req.req_type)
      REQ_READ: begin
        if (in_id) begin
          rd = {24'd0, id_byte(req.offset[4:2])};
        end else begin
          unique case (req.offset)
            ADDR_DR:   rd = vis_cnt;
            ADDR_MR:   rd = match_r;
            ADDR_LR:   rd = load_r;
            ADDR_CR:   rd = ctrl_r;
            ADDR_IMSC: rd = mask_r;
            ADDR_RIS:  rd = {31'd0, raw_r};
            ADDR_MIS:  rd = {31'd0, raw_r & mask_r[0]};
            default:   rd = '0;
          endcase
        end
      end
      REQ_WRITE: begin
        unique case (req.offset)
          ADDR_MR: begin
            match_nxt = req.write_data;
            armed_nxt = 1'b1;
          end
          ADDR_LR: begin
            load_nxt    = req.write_data;
            cnt_ofs_nxt = req.write_data - host_cnt;
          end
          ADDR_CR:   ctrl_nxt = req.write_data;
          ADDR_IMSC: mask_nxt = req.write_data;
          ADDR_ICR:  raw_nxt  = raw_r & ~req.write_data[0];
          default: ;
        endcase
      end
      REQ_TICK: begin
        if (armed_r && (vis_cnt >= match_r)) begin
          fire      = 1'b1;
          raw_nxt   = 1'b1;
          armed_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r    <= 1'b0;
      match_r   <= '0;
      load_r    <= '0;
      ctrl_r    <= '0;
      mask_r    <= '0;
      cnt_ofs_r <= '0;
      raw_r     <= 1'b0;
      armed_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        live_r <= cfg_wdata;
      end
      if (advance) begin
        match_r   <= match_nxt;
        load_r    <= load_nxt;
        ctrl_r    <= ctrl_nxt;
        mask_r    <= mask_nxt;
        cnt_ofs_r <= cnt_ofs_nxt;
        raw_r     <= raw_nxt;
        armed_r   <= armed_nxt;
      end
    end
  end

  // The interrupt level in a result is the raw status after its request, masked by bit 0 of the mask.
  assign res.read_data  = rd;
  assign res.irq_level  = raw_nxt & mask_nxt[0];

  assign status.armed     = armed_r;
  assign status.raw       = raw_r;
  assign status.tick_fire = advance && fire;

endmodule

`default_nettype wire

FILE: hdl/rtcma_out_stage.sv
// ----------------------------------------------------------------------------
// rtcma_out_stage
// Result register: holds a result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rtcma_out_stage
  import rtcma_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic req_valid,
  input  res_t res,
  output logic advance,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  // The held request moves on when the result register is free or draining.
  assign advance   = req_valid && (!valid_r || out_ready);
  assign valid_nxt = advance ? 1'b1 : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

FILE: hdl/rtc_match_alarm_registers.sv
// ----------------------------------------------------------------------------
// rtc_match_alarm_registers
// RTC register block with a count offset, a one-shot match alarm and ID words.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload                                        Handshake
//  in_ch     in   req_type, offset, write_data, host_seconds     valid/ready
//  out_ch    out  read_data, irq_level                           valid/ready
//  cfg_*     in   cfg_wdata (live clock select)                  cfg_we
//
//  One request per cycle while out_ch takes results; a result is offered once
//  its request has passed the input register, then the result register.
//  The adder and compare for the visible count sit between those registers.
//  rst_n (synchronous) clears valid flags and core registers, clock select too.
//  A stalled result holds the result register, and the input register then
//  holds one more request before in_ch.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rtc_match_alarm_registers_macros.svh"

module rtc_match_alarm_registers
  import rtcma_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  rtcma_req_if.sink   in_ch,
  rtcma_res_if.source out_ch
);

  req_t          in_req;
  req_t          req;
  res_t          res;
  res_t          out_res;
  rtcma_status_t status;
  logic          req_valid;
  logic          advance;

  assign in_req.req_type     = in_ch.req_type;
  assign in_req.offset       = in_ch.offset;
  assign in_req.write_data   = in_ch.write_data;
  assign in_req.host_seconds = in_ch.host_seconds;

  rtcma_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_req    (in_req),
    .advance   (advance),
    .req_valid (req_valid),
    .req       (req)
  );

  rtcma_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .advance   (advance),
    .req       (req),
    .res       (res),
    .status    (status)
  );

  rtcma_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.read_data = out_res.read_data;
  assign out_ch.irq_level = out_res.irq_level;

  // A held request is never lost while the result side stalls.
  `RTCMA_ASSERT_NXT(a_hold_req, req_valid && !advance, req_valid, "held request dropped")
  // Raw status only rises through an alarm firing on a tick.
  `RTCMA_ASSERT_IMP(a_raw_rise, $past(rst_n) && $rose(status.raw), $past(status.tick_fire), "raw status set without alarm")
  // The alarm only disarms by firing, which leaves raw status set.
  `RTCMA_ASSERT_IMP(a_disarm, $past(rst_n) && $fell(status.armed), status.raw, "alarm disarmed without firing")
  // A firing alarm always yields a result with raw status behind it.
  `RTCMA_ASSERT_NXT(a_fire_res, status.tick_fire, out_ch.valid && status.raw, "fired alarm lost")

endmodule

`default_nettype wire
